// ===== design/cqe_pkg.sv =====
// Shared types, register indexes and constants for the coefficient quantizer.
package cqe_pkg;

  // Field widths fixed by the coefficient format.
  localparam int COEFF_W    = 16;
  localparam int POS_W      = 10;
  localparam int EOB_W      = 11;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Largest block the end-of-block logic is sized for.
  localparam int BLOCK_COEFFS_DEF = 1024;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_ZERO_BIN    = 3'd0;
  localparam cfg_idx_t REG_ROUNDING    = 3'd1;
  localparam cfg_idx_t REG_QUANT       = 3'd2;
  localparam cfg_idx_t REG_QUANT_SHIFT = 3'd3;
  localparam cfg_idx_t REG_DEQUANT     = 3'd4;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL_Q,
    S_MUL_S,
    S_MUL_D,
    S_FIN
  } cqe_state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PREP,
    OP_MUL_Q,
    OP_MUL_S,
    OP_MUL_D,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/cqe_ifs.sv =====
// Channel interfaces: coefficient input, result output and configuration write.
interface cqe_coeff_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coeff;
  logic [9:0]         scan_pos;
  logic               is_dc;
  logic               last;

  modport source (output valid, coeff, scan_pos, is_dc, last, input ready);
  modport sink (input valid, coeff, scan_pos, is_dc, last, output ready);
endinterface

interface cqe_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] qcoeff;
  logic signed [15:0] dqcoeff;
  logic [10:0]        eob;
  logic               last_out;

  modport source (output valid, qcoeff, dqcoeff, eob, last_out, input ready);
  modport sink (input valid, qcoeff, dqcoeff, eob, last_out, output ready);
endinterface

interface cqe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/coefficient_quantizer_eob.sv =====
// Top level of the coefficient quantizer with running end-of-block tracking.
//
// Each coefficient request passes through a capture cycle, a preparation step
// (magnitude, zero-bin test and saturating rounding add) and three passes
// through one shared 16x16 signed multiplier (quantiser, shift multiplier,
// dequantiser), then a finish step that writes the result register. The block
// takes no new request while one is in progress: after the finish step it
// returns to the idle state in which the next request is captured. The result
// register lets a finished result wait for the consumer while the next request
// is accepted; if it is still full at the finish step the block holds until it
// drains. Configuration writes are always accepted and must only be made while
// the block is idle. Scan positions beyond the block size are clamped to the
// last position before they enter the end-of-block maximum.
module coefficient_quantizer_eob #(
  parameter int BLOCK_COEFFS = cqe_pkg::BLOCK_COEFFS_DEF
) (
  input logic         clk,
  input logic         rst,
  cqe_coeff_if.sink   coeff_in,
  cqe_result_if.source result_out,
  cqe_cfg_if.sink     cfg
);
  import cqe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign coeff_in.ready = in_ready;
  assign cfg.ready      = 1'b1;

  cqe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (coeff_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cqe_datapath #(
    .BLOCK_COEFFS (BLOCK_COEFFS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .coeff     (coeff_in.coeff),
    .scan_pos  (coeff_in.scan_pos),
    .is_dc     (coeff_in.is_dc),
    .last      (coeff_in.last),
    .cmd       (cmd),
    .status    (status),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .qcoeff    (result_out.qcoeff),
    .dqcoeff   (result_out.dqcoeff),
    .eob       (result_out.eob),
    .last_out  (result_out.last_out)
  );

endmodule

// ===== design/cqe_ctrl.sv =====
// Sequencing controller: steps one coefficient through the shared multiplier.
module cqe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cqe_pkg::dp_status_t status,
  output cqe_pkg::dp_cmd_t    cmd
);
  import cqe_pkg::*;

  cqe_state_t state;
  cqe_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PREP;
      end
      S_PREP:  state_next = S_MUL_Q;
      S_MUL_Q: state_next = S_MUL_S;
      S_MUL_S: state_next = S_MUL_D;
      S_MUL_D: state_next = S_FIN;
      S_FIN: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.op   = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_PREP:  cmd.op = OP_PREP;
      S_MUL_Q: cmd.op = OP_MUL_Q;
      S_MUL_S: cmd.op = OP_MUL_S;
      S_MUL_D: cmd.op = OP_MUL_D;
      S_FIN: begin
        if (status.out_free) cmd.op = OP_FINISH;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // An accepted request always starts the preparation step.
  a_accept_to_prep: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_PREP))
    else $error("accepted request did not start processing");

  // The finish step only issues when the result register can take it.
  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FINISH) |-> status.out_free)
    else $error("finish issued with result register occupied");

  // No new request is taken while a coefficient is in progress.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("request accepted while busy");

endmodule

// ===== design/cqe_datapath.sv =====
// Quantizer datapath: configuration registers, shared multiplier, result register.
module cqe_datapath #(
  parameter int BLOCK_COEFFS = cqe_pkg::BLOCK_COEFFS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration writes.
  input  logic                       cfg_we,
  input  cqe_pkg::cfg_idx_t          cfg_index,
  input  logic [31:0]                cfg_data,
  // Input payload.
  input  logic signed [15:0]         coeff,
  input  logic [9:0]                 scan_pos,
  input  logic                       is_dc,
  input  logic                       last,
  // Controller link.
  input  cqe_pkg::dp_cmd_t           cmd,
  output cqe_pkg::dp_status_t        status,
  // Result register.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [15:0]         qcoeff,
  output logic signed [15:0]         dqcoeff,
  output logic [10:0]                eob,
  output logic                       last_out
);
  import cqe_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(BLOCK_COEFFS - 1);
  localparam logic [EOB_W-1:0] EOB_MAX = EOB_W'(BLOCK_COEFFS);

  // Configuration registers.
  logic [31:0] zero_bin_pair;
  logic [31:0] rounding_pair;
  logic [31:0] quant_pair;
  logic [31:0] quant_shift_pair;
  logic [31:0] dequant_pair;

  // Captured request.
  logic signed [15:0] coeff_r;
  logic [POS_W-1:0]   pos_r;
  logic               dc_r;
  logic               last_r;

  // Intermediate values.
  logic signed [15:0] rnd_val;
  logic               pass_r;
  logic signed [15:0] q_r;
  logic signed [31:0] prod;
  logic [EOB_W-1:0]   eob_running;

  logic signed [15:0] zbin_h, rnd_h, qm_h, qs_h, dqm_h;
  logic signed [15:0] abs_c;
  logic signed [16:0] sum_r;
  logic signed [15:0] sat_r;
  logic signed [15:0] t_val;
  logic signed [15:0] q_raw;
  logic signed [15:0] q_val;
  logic signed [15:0] mul_a;
  logic signed [15:0] mul_b;
  logic [EOB_W-1:0]   pos_plus;
  logic [EOB_W-1:0]   eob_new;
  logic               load_out;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_bin_pair    <= '0;
      rounding_pair    <= '0;
      quant_pair       <= '0;
      quant_shift_pair <= '0;
      dequant_pair     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZERO_BIN:    zero_bin_pair    <= cfg_data;
        REG_ROUNDING:    rounding_pair    <= cfg_data;
        REG_QUANT:       quant_pair       <= cfg_data;
        REG_QUANT_SHIFT: quant_shift_pair <= cfg_data;
        REG_DEQUANT:     dequant_pair     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the DC or AC half of each parameter.
  assign zbin_h = dc_r ? zero_bin_pair[15:0]    : zero_bin_pair[31:16];
  assign rnd_h  = dc_r ? rounding_pair[15:0]    : rounding_pair[31:16];
  assign qm_h   = dc_r ? quant_pair[15:0]       : quant_pair[31:16];
  assign qs_h   = dc_r ? quant_shift_pair[15:0] : quant_shift_pair[31:16];
  assign dqm_h  = dc_r ? dequant_pair[15:0]     : dequant_pair[31:16];

  // Wrapping magnitude and saturating rounding add.
  assign abs_c = coeff_r[15] ? -coeff_r : coeff_r;
  assign sum_r = {abs_c[15], abs_c} + {rnd_h[15], rnd_h};
  always_comb begin
    if (sum_r[16] != sum_r[15]) begin
      sat_r = sum_r[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sat_r = sum_r[15:0];
    end
  end

  // First-stage result plus rounded value, and the sign and zero-bin fix-up.
  assign t_val = prod[31:16] + rnd_val;
  assign q_raw = coeff_r[15] ? -prod[31:16] : prod[31:16];
  assign q_val = pass_r ? q_raw : 16'sd0;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = rnd_val;
    mul_b = qm_h;
    case (cmd.op)
      OP_MUL_S: begin
        mul_a = t_val;
        mul_b = qs_h;
      end
      OP_MUL_D: begin
        mul_a = q_val;
        mul_b = dqm_h;
      end
      default: begin
        mul_a = rnd_val;
        mul_b = qm_h;
      end
    endcase
  end

  // Capture the request and step the arithmetic.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coeff_r <= coeff;
      pos_r   <= (scan_pos > POS_MAX) ? POS_MAX : scan_pos;
      dc_r    <= is_dc;
      last_r  <= last;
    end
    case (cmd.op)
      OP_PREP: begin
        rnd_val <= sat_r;
        pass_r  <= (abs_c >= zbin_h);
      end
      OP_MUL_Q, OP_MUL_S: begin
        prod <= mul_a * mul_b;
      end
      OP_MUL_D: begin
        prod <= mul_a * mul_b;
        q_r  <= q_val;
      end
      default: ;
    endcase
  end

  // Running end of block including this coefficient.
  assign pos_plus = {1'b0, pos_r} + EOB_W'(1);
  assign eob_new  = ((q_r != 16'sd0) && (pos_plus > eob_running)) ? pos_plus : eob_running;
  assign load_out = (cmd.op == OP_FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      eob_running <= '0;
    end else if (load_out) begin
      eob_running <= last_r ? '0 : eob_new;
    end
  end

  // Result register, free when empty or being taken this cycle.
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      qcoeff   <= q_r;
      dqcoeff  <= prod[15:0];
      eob      <= eob_new;
      last_out <= last_r;
    end
  end

  // A coefficient that fails the zero bin never yields a nonzero value.
  a_zero_bin: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_MUL_D && !pass_r) |=> (q_r == 16'sd0))
    else $error("coefficient below zero bin quantized to nonzero");

  // The end of block restarts after the final coefficient.
  a_eob_clear: assert property (@(posedge clk) disable iff (rst)
    (load_out && last_r) |=> (eob_running == '0))
    else $error("end of block not cleared after final coefficient");

  // The running end of block never passes the block size.
  a_eob_bound: assert property (@(posedge clk) disable iff (rst)
    eob_running <= EOB_MAX)
    else $error("end of block beyond block size");

endmodule
